// ----- sv/barometric_pressure_compensation_defines.svh -----
// =============================================================================
// barometric pressure compensation assertion macros
// shared property forms for the compensation datapath checks
// =============================================================================
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH

// same-cycle implication
`define BPC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpc check failed");

// next-cycle implication
`define BPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpc check failed");

`endif

// ----- sv/bpc_pkg.sv -----
// =============================================================================
// bpc_pkg
// shared types, constants and helpers for barometric pressure compensation
// =============================================================================
package bpc_pkg;

  localparam int DIV_W   = 32;
  localparam int PADDR_W = 5;

  localparam logic [31:0] T_OFFSET   = 32'd4000;
  localparam logic [31:0] P_C1       = 32'd3038;
  localparam logic [31:0] P_C2       = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_C3       = 32'd3791;
  localparam logic [15:0] B7_SCALE   = 16'd50000;
  localparam logic [31:0] B4_BIAS    = 32'd32768;
  localparam logic [31:0] MSB_32     = 32'h8000_0000;

  typedef enum logic [2:0] {
    REG_AC1_AC2  = 3'd0,
    REG_AC3_AC4  = 3'd1,
    REG_AC5_AC6  = 3'd2,
    REG_B1_B2    = 3'd3,
    REG_MC_MD    = 3'd4,
    REG_OSS      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
    logic [1:0]  oss;
  } cal_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // signed divide by 2^k, truncating toward zero
  function automatic logic [31:0] sdiv_p2(input logic [31:0] v, input logic [4:0] k);
    logic [31:0] bias;
    bias = v[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    return 32'($signed(v + bias) >>> k);
  endfunction

endpackage

// ----- sv/bpc_if.sv -----
// =============================================================================
// bpc channel interfaces
// raw sample channel and compensated result channel
// =============================================================================
interface bpc_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [23:0] raw_pressure;
  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bpc_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature;
  logic signed [31:0] pressure;
  logic               div_fault;
  modport source (output valid, output temperature, output pressure, output div_fault,
                  input ready);
  modport sink (input valid, input temperature, input pressure, input div_fault,
                output ready);
endinterface

// ----- sv/barometric_pressure_compensation.sv -----
// throughput: one sample per cycle while the result is not stalled; the two 32-stage divider pipelines set the depth
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
// reset: synchronous, clears all valid bits and calibration registers to zero
// =============================================================================
// barometric_pressure_compensation
// integer temperature and pressure compensation, fully pipelined
// =============================================================================
`include "barometric_pressure_compensation_defines.svh"

module barometric_pressure_compensation (
  input  logic                         clk,
  input  logic                         rst,
  bpc_sample_if.sink                   sample,
  bpc_result_if.source                 result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int N = bpc_pkg::DIV_W;

  typedef struct packed {
    logic [31:0] x1;
    logic [31:0] up;
    logic        neg;
    logic        fault;
  } sba_t;

  typedef struct packed {
    logic [31:0] t;
    logic        fault;
    logic        branch;
  } sbb_t;

  bpc_pkg::cal_t cal;
  logic en;

  bpc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cal
  );

  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  // stage 1: shift raw pressure, first product
  logic        s1_v;
  logic [31:0] s1_prod, s1_up;
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= sample.valid;
    if (en) begin
      s1_prod <= 32'((32'(sample.raw_temperature) - 32'(cal.ac6)) * 32'(cal.ac5));
      s1_up   <= 32'(sample.raw_pressure) >> (4'd8 - 4'(cal.oss));
    end
  end

  // stage 2: divider a operands
  logic        s2_v, s2_neg, s2_dz;
  logic [31:0] s2_x1, s2_up, s2_na, s2_da;
  logic [31:0] x1a, dena, numa;
  always_comb begin
    x1a  = bpc_pkg::sdiv_p2(s1_prod, 5'd15);
    dena = x1a + bpc_pkg::sx16(cal.md);
    numa = bpc_pkg::sx16(cal.mc) << 11;
  end
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
    if (en) begin
      s2_x1  <= x1a;
      s2_up  <= s1_up;
      s2_dz  <= (dena == 32'd0);
      s2_neg <= numa[31] ^ dena[31];
      s2_na  <= numa[31] ? 32'(-numa) : numa;
      s2_da  <= dena[31] ? 32'(-dena) : dena;
    end
  end

  logic [31:0] qa;
  sba_t        sba_q [N];
  logic        va_q  [N];
  bpc_div u_div_a (.clk, .en, .num(s2_na), .den(s2_da), .quo(qa));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < N; s++) va_q[s] <= 1'b0;
    end else if (en) begin
      for (int s = 0; s < N; s++) va_q[s] <= (s == 0) ? s2_v : va_q[(s == 0) ? 0 : s - 1];
    end
    if (en) begin
      for (int s = 0; s < N; s++) begin
        sba_q[s] <= (s == 0) ? sba_t'{x1: s2_x1, up: s2_up, neg: s2_neg, fault: s2_dz}
                             : sba_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // stage 3: temperature, b6 and its square
  logic        s3_v, s3_f;
  logic [31:0] s3_t, s3_b6, s3_sqp, s3_up;
  logic [31:0] x2a, b5, b6;
  always_comb begin
    x2a = sba_q[N-1].neg ? 32'(-qa) : qa;
    b5  = sba_q[N-1].x1 + x2a;
    b6  = b5 - bpc_pkg::T_OFFSET;
  end
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= va_q[N-1];
    if (en) begin
      s3_f   <= sba_q[N-1].fault;
      s3_t   <= bpc_pkg::sdiv_p2(b5 + 32'd8, 5'd4);
      s3_b6  <= b6;
      s3_sqp <= 32'(b6 * b6);
      s3_up  <= sba_q[N-1].up;
    end
  end

  // stage 4: four coefficient products
  logic        s4_v, s4_f;
  logic [31:0] s4_t, s4_up, s4_p1, s4_p2, s4_p3, s4_p4;
  logic [31:0] sq;
  assign sq = bpc_pkg::sdiv_p2(s3_sqp, 5'd12);
  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= s3_v;
    if (en) begin
      s4_f  <= s3_f;
      s4_t  <= s3_t;
      s4_up <= s3_up;
      s4_p1 <= 32'(bpc_pkg::sx16(cal.b2) * sq);
      s4_p2 <= 32'(bpc_pkg::sx16(cal.ac2) * s3_b6);
      s4_p3 <= 32'(bpc_pkg::sx16(cal.ac3) * s3_b6);
      s4_p4 <= 32'(bpc_pkg::sx16(cal.b1) * sq);
    end
  end

  // stage 5: b3 and the b4 multiplicand
  logic        s5_v, s5_f;
  logic [31:0] s5_t, s5_up, s5_b3, s5_s;
  logic [31:0] x3, b3r, y3;
  always_comb begin
    x3  = bpc_pkg::sdiv_p2(s4_p1, 5'd11) + bpc_pkg::sdiv_p2(s4_p2, 5'd11);
    b3r = ((bpc_pkg::sx16(cal.ac1) << 2) + x3) << cal.oss;
    y3  = bpc_pkg::sdiv_p2(bpc_pkg::sdiv_p2(s4_p3, 5'd13) +
                           bpc_pkg::sdiv_p2(s4_p4, 5'd16) + 32'd2, 5'd2);
  end
  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (en) s5_v <= s4_v;
    if (en) begin
      s5_f  <= s4_f;
      s5_t  <= s4_t;
      s5_up <= s4_up;
      s5_b3 <= bpc_pkg::sdiv_p2(b3r + 32'd2, 5'd2);
      s5_s  <= y3 + bpc_pkg::B4_BIAS;
    end
  end

  // stage 6: b4 product and b7
  logic        s6_v, s6_f;
  logic [31:0] s6_t, s6_b4p, s6_b7;
  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else if (en) s6_v <= s5_v;
    if (en) begin
      s6_f   <= s5_f;
      s6_t   <= s5_t;
      s6_b4p <= 32'(32'(cal.ac4) * s5_s);
      s6_b7  <= 32'((s5_up - s5_b3) * 32'(bpc_pkg::B7_SCALE >> cal.oss));
    end
  end

  // divider b: b7 branch keeps the unsigned range
  logic [31:0] b4, numb, qb;
  logic        br;
  assign b4   = s6_b4p >> 15;
  assign br   = (s6_b7 < bpc_pkg::MSB_32);
  assign numb = br ? {s6_b7[30:0], 1'b0} : s6_b7;

  sbb_t sbb_q [N];
  logic vb_q  [N];
  bpc_div u_div_b (.clk, .en, .num(numb), .den(b4), .quo(qb));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < N; s++) vb_q[s] <= 1'b0;
    end else if (en) begin
      for (int s = 0; s < N; s++) vb_q[s] <= (s == 0) ? s6_v : vb_q[(s == 0) ? 0 : s - 1];
    end
    if (en) begin
      for (int s = 0; s < N; s++) begin
        sbb_q[s] <= (s == 0) ? sbb_t'{t: s6_t, fault: s6_f || (b4 == 32'd0), branch: br}
                             : sbb_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // stage 7: raw pressure and its correction products
  logic        s7_v, s7_f;
  logic [31:0] s7_t, s7_p, s7_m1, s7_m2;
  logic [31:0] pu, pd;
  always_comb begin
    pu = sbb_q[N-1].branch ? qb : {qb[30:0], 1'b0};
    pd = bpc_pkg::sdiv_p2(pu, 5'd8);
  end
  always_ff @(posedge clk) begin
    if (rst) s7_v <= 1'b0;
    else if (en) s7_v <= vb_q[N-1];
    if (en) begin
      s7_f  <= sbb_q[N-1].fault;
      s7_t  <= sbb_q[N-1].t;
      s7_p  <= pu;
      s7_m1 <= 32'(pd * pd);
      s7_m2 <= 32'(bpc_pkg::P_C2 * pu);
    end
  end

  // stage 8
  logic        s8_v, s8_f;
  logic [31:0] s8_t, s8_p, s8_m2, s8_m3;
  always_ff @(posedge clk) begin
    if (rst) s8_v <= 1'b0;
    else if (en) s8_v <= s7_v;
    if (en) begin
      s8_f  <= s7_f;
      s8_t  <= s7_t;
      s8_p  <= s7_p;
      s8_m2 <= s7_m2;
      s8_m3 <= 32'(s7_m1 * bpc_pkg::P_C1);
    end
  end

  // output word register
  logic [31:0] pf;
  assign pf = s8_p + bpc_pkg::sdiv_p2(bpc_pkg::sdiv_p2(s8_m3, 5'd16) +
                                      bpc_pkg::sdiv_p2(s8_m2, 5'd16) + bpc_pkg::P_C3, 5'd4);
  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (en) result.valid <= s8_v;
    if (en) begin
      result.div_fault   <= s8_f;
      result.temperature <= s8_f ? '0 : $signed(s8_t);
      result.pressure    <= s8_f ? '0 : $signed(pf);
    end
  end

  `BPC_ASSERT_NOW(a_fault_zero, clk, rst, result.valid && result.div_fault,
                  result.temperature == 0 && result.pressure == 0)
  `BPC_ASSERT_NEXT(a_stall_hold, clk, rst, result.valid && !result.ready,
                   $stable(s8_v) && $stable(vb_q[N-1]))
  `BPC_ASSERT_NOW(a_ready_stall, clk, rst, !sample.ready, result.valid)

endmodule

// ----- sv/bpc_cfg.sv -----
// =============================================================================
// bpc_cfg
// apb register file holding calibration words and oversampling setting
// =============================================================================
module bpc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output bpc_pkg::cal_t                cal
);

  logic [31:0] ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mc_md;
  logic [1:0]  oss;
  bpc_pkg::reg_idx_t idx;
  logic wr;

  assign idx    = bpc_pkg::reg_idx_t'(paddr[bpc_pkg::PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1_ac2 <= '0;
      ac3_ac4 <= '0;
      ac5_ac6 <= '0;
      b1_b2   <= '0;
      mc_md   <= '0;
      oss     <= '0;
    end else if (wr) begin
      unique case (idx)
        bpc_pkg::REG_AC1_AC2: ac1_ac2 <= pwdata;
        bpc_pkg::REG_AC3_AC4: ac3_ac4 <= pwdata;
        bpc_pkg::REG_AC5_AC6: ac5_ac6 <= pwdata;
        bpc_pkg::REG_B1_B2:   b1_b2   <= pwdata;
        bpc_pkg::REG_MC_MD:   mc_md   <= pwdata;
        bpc_pkg::REG_OSS:     oss     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bpc_pkg::REG_AC1_AC2: prdata = ac1_ac2;
      bpc_pkg::REG_AC3_AC4: prdata = ac3_ac4;
      bpc_pkg::REG_AC5_AC6: prdata = ac5_ac6;
      bpc_pkg::REG_B1_B2:   prdata = b1_b2;
      bpc_pkg::REG_MC_MD:   prdata = mc_md;
      bpc_pkg::REG_OSS:     prdata = {30'd0, oss};
      default:              prdata = '0;
    endcase
  end

  assign cal = '{ac1: ac1_ac2[31:16], ac2: ac1_ac2[15:0],
                 ac3: ac3_ac4[31:16], ac4: ac3_ac4[15:0],
                 ac5: ac5_ac6[31:16], ac6: ac5_ac6[15:0],
                 b1: b1_b2[31:16], b2: b1_b2[15:0],
                 mc: mc_md[31:16], md: mc_md[15:0], oss: oss};

endmodule

// ----- sv/bpc_div.sv -----
// =============================================================================
// bpc_div
// pipelined unsigned 32 by 32 restoring divider, one quotient bit per stage
// =============================================================================
module bpc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);

  localparam int N = bpc_pkg::DIV_W;

  logic [31:0] rem_q [N];
  logic [31:0] num_q [N];
  logic [31:0] den_q [N];
  logic [31:0] quo_q [N];
  logic [31:0] rem_next [N];
  logic [31:0] num_next [N];
  logic [31:0] quo_next [N];

  always_comb begin
    for (int s = 0; s < N; s++) begin
      logic [31:0] r_in, n_in, d_in, q_in;
      logic [32:0] trial;
      r_in = (s == 0) ? 32'd0 : rem_q[(s == 0) ? 0 : s - 1];
      n_in = (s == 0) ? num   : num_q[(s == 0) ? 0 : s - 1];
      d_in = (s == 0) ? den   : den_q[(s == 0) ? 0 : s - 1];
      q_in = (s == 0) ? 32'd0 : quo_q[(s == 0) ? 0 : s - 1];
      trial = {r_in, n_in[31]};
      if (trial >= {1'b0, d_in}) begin
        rem_next[s] = 32'(trial - {1'b0, d_in});
        quo_next[s] = {q_in[30:0], 1'b1};
      end else begin
        rem_next[s] = trial[31:0];
        quo_next[s] = {q_in[30:0], 1'b0};
      end
      num_next[s] = {n_in[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < N; s++) begin
        rem_q[s] <= rem_next[s];
        num_q[s] <= num_next[s];
        quo_q[s] <= quo_next[s];
        den_q[s] <= (s == 0) ? den : den_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign quo = quo_q[N-1];

endmodule
